// ===== rtl/dbep_pkg.sv =====
`default_nettype none

package dbep_pkg;

	localparam int VTX_W = 12;
	localparam int DEG_W = 32;
	localparam int NP_W  = 5;
	localparam int BKT_W = 4;
	localparam int LOAD_W = 32;
	localparam int MIR_W = 17;

	localparam int VERTEX_COUNT_DEF = 4096;
	localparam int PARTS_MAX_DEF    = 16;

	localparam logic [LOAD_W-1:0] LOAD_MAX   = '1;
	localparam logic [MIR_W-1:0]  MIRROR_MAX = '1;

	// remainder unit: bits of the dividend retired per cycle
	localparam int MOD_RADIX  = 4;
	localparam int MOD_STEPS  = VTX_W / MOD_RADIX;
	localparam int MOD_CNT_W  = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_EDGE  = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

	typedef struct packed {
		logic [1:0]       action;
		logic [VTX_W-1:0] first_vertex;
		logic [VTX_W-1:0] second_vertex;
		logic [DEG_W-1:0] degree_value;
	} in_item_t;

	typedef struct packed {
		logic [BKT_W-1:0]  bucket;
		logic [LOAD_W-1:0] bucket_load;
		logic [LOAD_W-1:0] max_load;
		logic [MIR_W-1:0]  mirror_marks;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DEG_B,
		ST_PICK,
		ST_MOD,
		ST_MARK_A_RD,
		ST_MARK_A_WR,
		ST_MARK_B_RD,
		ST_MARK_B_WR,
		ST_CLEAR,
		ST_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic deg_b;
		logic pick;
		logic bucket_latch;
		logic mark_wr;
		logic sel_b;
		logic count_upd;
		logic sweep;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic mod_done;
		logic sweep_last;
	} dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/dbep_ram.sv =====
`default_nettype none

module dbep_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/dbep_mod.sv =====
`default_nettype none

module dbep_mod
	import dbep_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [VTX_W-1:0] dividend,
	input  wire logic [NP_W-1:0]  divisor,
	output logic                  done,
	output logic      [NP_W-1:0]  remainder
);

	logic [NP_W-1:0]      div_q;
	logic [NP_W-1:0]      rem_q;
	logic [NP_W-1:0]      rem_d;
	logic [VTX_W-1:0]     dvd_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	// restoring remainder, several dividend bits per cycle
	always_comb begin
		logic [NP_W:0] t;
		rem_d = rem_q;
		for (int i = 0; i < MOD_RADIX; i++) begin
			t = {rem_d, dvd_q[VTX_W-1-i]};
			if (t >= {1'b0, div_q}) begin
				rem_d = NP_W'(t - {1'b0, div_q});
			end else begin
				rem_d = t[NP_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == MOD_CNT_W'(MOD_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_d;
			dvd_q <= dvd_q << MOD_RADIX;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== rtl/dbep_dp.sv =====
`default_nettype none

module dbep_dp
	import dbep_pkg::*;
#(
	parameter int VERTEX_COUNT = VERTEX_COUNT_DEF,
	parameter int PARTS_MAX    = PARTS_MAX_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_valid,
	input  wire logic [NP_W-1:0] cfg_data,
	input  wire in_item_t        in_data,
	input  wire dp_cmd_t         cmd,
	output dp_sts_t              sts,
	output out_item_t            out_data
);

	localparam int VW = $clog2(VERTEX_COUNT);
	localparam int BW = (PARTS_MAX > 1) ? $clog2(PARTS_MAX) : 1;
	localparam logic [31:0] VCOUNT = 32'(VERTEX_COUNT);

	logic [NP_W-1:0]      num_parts_q;
	logic [NP_W-1:0]      np;
	in_item_t             item_q;
	logic                 va_ok_q, vb_ok_q;
	logic [DEG_W-1:0]     deg_a_q;
	logic [BW-1:0]        bucket_q;
	logic [LOAD_W-1:0]    load_q;
	logic [LOAD_W-1:0]    max_q;
	logic [MIR_W-1:0]     mirror_q;
	logic [PARTS_MAX-1:0] cnt_vld_q;
	logic [VW-1:0]        sweep_q;
	out_item_t            out_q;

	logic                 in_clear;
	logic                 in_va_ok;

	logic                 deg_we;
	logic [VW-1:0]        deg_raddr;
	logic [DEG_W-1:0]     deg_rdata;
	logic [DEG_W-1:0]     deg_b;
	logic [VTX_W-1:0]     winner;
	logic                 mod_done;
	logic [NP_W-1:0]      mod_rem;

	logic                 pres_we;
	logic [VW-1:0]        pres_waddr;
	logic [PARTS_MAX-1:0] pres_wdata;
	logic [VW-1:0]        pres_raddr;
	logic [PARTS_MAX-1:0] pres_rdata;
	logic [PARTS_MAX-1:0] pres_bit;
	logic                 mark_ok;
	logic                 mark_new;

	logic [LOAD_W-1:0]    cnt_rdata;
	logic [LOAD_W-1:0]    cnt_cur;
	logic [LOAD_W-1:0]    cnt_next;

	assign in_clear = cmd.accept && (in_data.action == ACT_CLEAR);
	assign in_va_ok = {20'b0, in_data.first_vertex} < VCOUNT;

	// zero counts as one, anything past PARTS_MAX clamps to it
	always_comb begin
		if (num_parts_q == '0) begin
			np = NP_W'(1);
		end else if (32'(num_parts_q) > 32'(PARTS_MAX)) begin
			np = NP_W'(PARTS_MAX);
		end else begin
			np = num_parts_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_parts_q <= NP_W'(1);
		end else if (cfg_valid) begin
			num_parts_q <= cfg_data;
		end
	end

	// ---- degree table ----
	assign deg_we    = cmd.accept && (in_data.action == ACT_LOAD) && in_va_ok;
	assign deg_raddr = cmd.accept ? VW'(in_data.first_vertex) : VW'(item_q.second_vertex);

	dbep_ram #(
		.WIDTH(DEG_W),
		.DEPTH(VERTEX_COUNT)
	) u_deg_ram (
		.clk  (clk),
		.we   (deg_we),
		.waddr(VW'(in_data.first_vertex)),
		.wdata(in_data.degree_value),
		.raddr(deg_raddr),
		.rdata(deg_rdata)
	);

	assign deg_b  = vb_ok_q ? deg_rdata : '0;
	assign winner = (deg_a_q <= deg_b) ? item_q.first_vertex : item_q.second_vertex;

	dbep_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.pick),
		.dividend (winner),
		.divisor  (np),
		.done     (mod_done),
		.remainder(mod_rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q  <= in_data;
			va_ok_q <= in_va_ok;
			vb_ok_q <= {20'b0, in_data.second_vertex} < VCOUNT;
		end
		if (cmd.deg_b) begin
			deg_a_q <= va_ok_q ? deg_rdata : '0;
		end
		if (cmd.bucket_latch) begin
			bucket_q <= BW'(mod_rem);
		end
	end

	// ---- presence marks ----
	assign pres_bit   = PARTS_MAX'(1) << bucket_q;
	assign pres_raddr = cmd.sel_b ? VW'(item_q.second_vertex) : VW'(item_q.first_vertex);
	assign mark_ok    = cmd.sel_b ? vb_ok_q : va_ok_q;
	assign mark_new   = cmd.mark_wr && mark_ok && ((pres_rdata & pres_bit) == '0);

	always_comb begin
		if (cmd.sweep) begin
			pres_we    = 1'b1;
			pres_waddr = sweep_q;
			pres_wdata = '0;
		end else begin
			pres_we    = mark_new;
			pres_waddr = pres_raddr;
			pres_wdata = pres_rdata | pres_bit;
		end
	end

	dbep_ram #(
		.WIDTH(PARTS_MAX),
		.DEPTH(VERTEX_COUNT)
	) u_pres_ram (
		.clk  (clk),
		.we   (pres_we),
		.waddr(pres_waddr),
		.wdata(pres_wdata),
		.raddr(pres_raddr),
		.rdata(pres_rdata)
	);

	assign sts.sweep_last = (sweep_q == VW'(VERTEX_COUNT - 1));
	assign sts.mod_done   = mod_done;

	// ---- partition counts ----
	assign cnt_cur  = cnt_vld_q[bucket_q] ? cnt_rdata : '0;
	assign cnt_next = (cnt_cur == LOAD_MAX) ? cnt_cur : cnt_cur + 1'b1;

	dbep_ram #(
		.WIDTH(LOAD_W),
		.DEPTH(PARTS_MAX)
	) u_cnt_ram (
		.clk  (clk),
		.we   (cmd.count_upd),
		.waddr(bucket_q),
		.wdata(cnt_next),
		.raddr(bucket_q),
		.rdata(cnt_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
			max_q     <= '0;
			mirror_q  <= '0;
			sweep_q   <= '0;
		end else begin
			if (in_clear) begin
				cnt_vld_q <= '0;
				max_q     <= '0;
				mirror_q  <= '0;
			end else begin
				if (cmd.count_upd) begin
					cnt_vld_q[bucket_q] <= 1'b1;
					if (cnt_next > max_q) begin
						max_q <= cnt_next;
					end
				end
				if (mark_new && (mirror_q != MIRROR_MAX)) begin
					mirror_q <= mirror_q + 1'b1;
				end
			end
			if (cmd.sweep) begin
				sweep_q <= sts.sweep_last ? '0 : sweep_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.count_upd) begin
			load_q <= cnt_next;
		end
		if (cmd.out_load) begin
			if (item_q.action == ACT_EDGE) begin
				out_q.bucket      <= BKT_W'(bucket_q);
				out_q.bucket_load <= load_q;
			end else begin
				out_q.bucket      <= '0;
				out_q.bucket_load <= '0;
			end
			out_q.max_load     <= max_q;
			out_q.mirror_marks <= mirror_q;
		end
	end

	assign out_data = out_q;

	a_mirror_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!in_clear |=> mirror_q >= $past(mirror_q))
		else $error("mirror total dropped without a clear");

	a_load_within_max: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.count_upd |=> load_q <= max_q)
		else $error("bucket load exceeds running maximum");

	a_rem_below_modulus: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> mod_rem < np)
		else $error("remainder not below modulus");

endmodule

`default_nettype wire

// ===== rtl/dbep_ctrl.sv =====
`default_nettype none

module dbep_ctrl
	import dbep_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [1:0] in_action,
	output logic            in_stall,
	output logic            out_valid,
	input  wire logic       out_stall,
	input  wire dp_sts_t    sts,
	output dp_cmd_t         cmd
);

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_INIT: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					unique case (in_action)
						ACT_EDGE:  state_d = ST_DEG_B;
						ACT_CLEAR: state_d = ST_CLEAR;
						default:   state_d = ST_FINISH;
					endcase
				end
			end
			ST_DEG_B: begin
				cmd.deg_b = 1'b1;
				state_d   = ST_PICK;
			end
			ST_PICK: begin
				cmd.pick = 1'b1;
				state_d  = ST_MOD;
			end
			ST_MOD: begin
				if (sts.mod_done) begin
					cmd.bucket_latch = 1'b1;
					state_d          = ST_MARK_A_RD;
				end
			end
			ST_MARK_A_RD: begin
				state_d = ST_MARK_A_WR;
			end
			ST_MARK_A_WR: begin
				cmd.mark_wr   = 1'b1;
				cmd.count_upd = 1'b1;
				state_d       = ST_MARK_B_RD;
			end
			ST_MARK_B_RD: begin
				cmd.sel_b = 1'b1;
				state_d   = ST_MARK_B_WR;
			end
			ST_MARK_B_WR: begin
				cmd.mark_wr = 1'b1;
				cmd.sel_b   = 1'b1;
				state_d     = ST_FINISH;
			end
			ST_CLEAR: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// hold until the output register frees up
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_mod_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.mod_done |-> state_q == ST_MOD)
		else $error("remainder finished outside its wait state");

	a_sweep_end_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		sts.sweep_last |-> (state_q == ST_INIT || state_q == ST_CLEAR))
		else $error("sweep counter at its end outside a clearing pass");

	a_no_result_during_init: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INIT |-> !out_valid_q)
		else $error("result pending during the reset sweep");

endmodule

`default_nettype wire

// ===== rtl/degree_based_edge_partitioner.sv =====
// Degree-based hashing edge partitioner.
// Input channel in_valid/in_stall/in_data carries one command transaction:
// load a degree entry, assign an edge, or clear the tallies. Every accepted
// transaction yields exactly one result transaction on out_valid/out_stall/out_data.
// cfg_valid/cfg_ready/cfg_data writes num_parts; cfg_ready is always high,
// write only while the block is idle.
// Items are taken one at a time. A load or an unused action goes from accept
// through the finish state back to idle; an edge does two degree reads
// on the single read port, runs the 4-bit-per-cycle remainder unit,
// and does read-modify-write of both presence entries, one after the other.
// A clear sweeps the presence RAM one entry per cycle.
// The result is loaded into an output register once that register frees up.
// After reset the same sweep runs over all presence entries with in_stall high;
// cfg writes are taken during it. Degree entries are not cleared.
// When the receiver stalls, the result holds and the block still accepts one
// more item, finishing it and waiting until the output register frees up.
`default_nettype none

module degree_based_edge_partitioner
	import dbep_pkg::*;
#(
	parameter int VERTEX_COUNT = VERTEX_COUNT_DEF,
	parameter int PARTS_MAX    = PARTS_MAX_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [NP_W-1:0] cfg_data,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire in_item_t        in_data,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output out_item_t            out_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	dbep_dp #(
		.VERTEX_COUNT(VERTEX_COUNT),
		.PARTS_MAX   (PARTS_MAX)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

	dbep_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_action(in_data.action),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dbep_pkg::*;

	localparam int VERTICES = VERTEX_COUNT_DEF;
	localparam int PARTS_LIMIT = PARTS_MAX_DEF;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int TAIL_CYCLES = 40;
	localparam int MAX_PRINTS = 40;
	localparam int PHASE_ITEMS = 300;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	class partition_scoreboard;
		logic [DEG_W-1:0] deg_mem [VERTICES];
		logic [PARTS_LIMIT-1:0] part_marks [VERTICES];
		logic [LOAD_W-1:0] edge_tally [PARTS_LIMIT];
		logic [LOAD_W-1:0] peak_load;
		logic [MIR_W-1:0] mirror_count;
		logic [NP_W-1:0] parts_cfg;
		out_item_t expected_results [$];
		int error_count;

		function new();
			foreach (deg_mem[i]) deg_mem[i] = '0;
			clear_tallies();
			parts_cfg = 1;
			error_count = 0;
		endfunction

		function void clear_tallies();
			foreach (part_marks[i]) part_marks[i] = '0;
			foreach (edge_tally[i]) edge_tally[i] = '0;
			peak_load = '0;
			mirror_count = '0;
		endfunction

		function void set_marker(logic [VTX_W-1:0] v, int unsigned slot);
			if (!part_marks[v][slot]) begin
				part_marks[v][slot] = 1'b1;
				if (mirror_count != MIRROR_MAX)
					mirror_count++;
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		// predict the result of one accepted command transaction
		function void note_command(in_item_t cmd);
			out_item_t res;
			logic [VTX_W-1:0] owner;
			int unsigned modulus;
			int unsigned slot;
			res = '0;
			case (cmd.action)
			ACT_LOAD: deg_mem[cmd.first_vertex] = cmd.degree_value;
			ACT_EDGE: begin
				// lower degree wins, first endpoint on a tie
				owner = (deg_mem[cmd.first_vertex] <= deg_mem[cmd.second_vertex]) ?
					cmd.first_vertex : cmd.second_vertex;
				if (parts_cfg == 0)
					modulus = 1;
				else if (parts_cfg > PARTS_LIMIT)
					modulus = PARTS_LIMIT;
				else
					modulus = parts_cfg;
				slot = owner % modulus;
				if (edge_tally[slot] != LOAD_MAX)
					edge_tally[slot]++;
				if (edge_tally[slot] > peak_load)
					peak_load = edge_tally[slot];
				set_marker(cmd.first_vertex, slot);
				set_marker(cmd.second_vertex, slot);
				res.bucket = BKT_W'(slot);
				res.bucket_load = edge_tally[slot];
			end
			ACT_CLEAR: clear_tallies();
			default: ;
			endcase
			res.max_load = peak_load;
			res.mirror_marks = mirror_count;
			expected_results.push_back(res);
		endfunction

		task report(string what);
			error_count++;
			if (error_count <= MAX_PRINTS)
				$display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			if (expected_results.size() == 0) begin
				report($sformatf("unexpected result %p", got));
			end else begin
				want = expected_results.pop_front();
				if (got.bucket !== want.bucket)
					report($sformatf("bucket got %0d want %0d", got.bucket, want.bucket));
				if (got.bucket_load !== want.bucket_load)
					report($sformatf("bucket_load got %0d want %0d",
						got.bucket_load, want.bucket_load));
				if (got.max_load !== want.max_load)
					report($sformatf("max_load got %0d want %0d", got.max_load, want.max_load));
				if (got.mirror_marks !== want.mirror_marks)
					report($sformatf("mirror_marks got %0d want %0d",
						got.mirror_marks, want.mirror_marks));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [NP_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;

	partition_scoreboard sb = new();

	bit loaded_map [VERTICES];
	int unsigned loaded_list [$];
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int unsigned hold_request = 0;
	int unsigned hold_left = 0;
	int unsigned stall_left = 0;
	int unsigned quiet_cycles = 0;

	degree_based_edge_partitioner DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always #6 clk = ~clk;

	function in_item_t make_item(logic [1:0] act, int unsigned a, int unsigned b,
			logic [DEG_W-1:0] d);
		in_item_t it;
		it.action = act;
		it.first_vertex = VTX_W'(a);
		it.second_vertex = VTX_W'(b);
		it.degree_value = d;
		if (act == ACT_LOAD && !loaded_map[a]) begin
			loaded_map[a] = 1'b1;
			loaded_list.push_back(a);
		end
		return it;
	endfunction

	function int unsigned any_loaded();
		return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
	endfunction

	function logic [DEG_W-1:0] random_degree();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return $urandom_range(0, 15);
		else if (r < 80)
			return $urandom_range(0, 1000);
		else if (r < 95)
			return $urandom();
		else
			return '1;
	endfunction

	// mostly edges over loaded vertices, some loads, rare clears and noise
	function in_item_t random_item();
		int unsigned r;
		int unsigned a;
		r = $urandom_range(0, 999);
		if (r < 6)
			return make_item(ACT_CLEAR, $urandom_range(0, VERTICES - 1),
				$urandom_range(0, VERTICES - 1), $urandom());
		if (r < 26)
			return make_item(ACT_UNUSED, $urandom_range(0, VERTICES - 1),
				$urandom_range(0, VERTICES - 1), $urandom());
		if (r < 250) begin
			a = ($urandom_range(0, 3) == 0) ? any_loaded() : $urandom_range(0, VERTICES - 1);
			return make_item(ACT_LOAD, a, $urandom_range(0, VERTICES - 1), random_degree());
		end
		a = any_loaded();
		return make_item(ACT_EDGE, a, ($urandom_range(0, 19) == 0) ? a : any_loaded(),
			$urandom());
	endfunction

	function int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (!tx_idle_on || r < 65)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(15, 50);
	endfunction

	task send_item(in_item_t it);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		sb.note_command(it);
	endtask

	task drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task write_parts(logic [NP_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.parts_cfg = v;
		cfg_valid <= 1'b0;
	endtask

	// result side: check, then decide the stall for the next cycle
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_result(out_data);
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			if (stall_left == 0 && rx_idle_on && $urandom_range(0, 99) < 20)
				stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) :
					$urandom_range(1, 3);
			out_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("degree_based_edge_partitioner test failed");
				$finish;
			end
		end
	end

	initial begin
		logic [NP_W-1:0] phase_parts [6];
		int unsigned n;
		phase_parts = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd0};
		phase_parts[5] = NP_W'($urandom_range(2, 15));
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// taken while the presence sweep after reset still runs
		write_parts(5'd4);

		send_item(make_item(ACT_LOAD, 0, 0, '0));
		send_item(make_item(ACT_LOAD, 4095, 4095, '1));
		send_item(make_item(ACT_LOAD, 1, 0, '1));
		send_item(make_item(ACT_LOAD, 2, 0, 32'd5));
		send_item(make_item(ACT_LOAD, 3, 0, 32'd5));
		send_item(make_item(ACT_LOAD, 12'hAAA, 12'h555, 32'hAAAA_AAAA));
		send_item(make_item(ACT_LOAD, 12'h555, 12'hAAA, 32'h5555_5555));
		send_item(make_item(ACT_EDGE, 0, 4095, '0));
		send_item(make_item(ACT_EDGE, 4095, 0, '1));
		send_item(make_item(ACT_EDGE, 2, 3, '0));
		send_item(make_item(ACT_EDGE, 3, 2, '0));
		send_item(make_item(ACT_EDGE, 1, 4095, '0));
		send_item(make_item(ACT_EDGE, 12'hAAA, 12'h555, '0));
		send_item(make_item(ACT_EDGE, 4095, 4095, '0));
		send_item(make_item(ACT_UNUSED, 4095, 4095, '1));
		send_item(make_item(ACT_EDGE, 3, 1, '0));
		send_item(make_item(ACT_CLEAR, 4095, 4095, '1));
		send_item(make_item(ACT_EDGE, 0, 12'h555, '0));
		send_item(make_item(ACT_LOAD, 0, 0, 32'd7));
		send_item(make_item(ACT_EDGE, 0, 2, '0));
		drain_results();

		for (int phase = 0; phase < 6; phase++) begin
			write_parts(phase_parts[phase]);
			tx_idle_on = (phase % 3 != 1);
			rx_idle_on = tx_idle_on;
			// fill the block while the receiver holds off
			if (phase == 2)
				hold_request = 400;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 3 && n == PHASE_ITEMS / 2)
					drain_results();
				send_item(random_item());
			end
			drain_results();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		if (sb.error_count == 0)
			$display("degree_based_edge_partitioner test passed");
		else
			$display("degree_based_edge_partitioner test failed");
		$finish;
	end

endmodule

`default_nettype wire
